FILE: design/bed_pkg.sv
// Shared types, constants and helper functions of the bounded edit distance block.
package bed_pkg;

  // Longest word that is stored; longer words set the overflow flag.
  localparam int MAX_LEN = 32;
  // Width of a length count that can hold MAX_LEN itself.
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  // Address width of the reference store and of the row store.
  localparam int ADDR_W = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
  // Row entries and distances saturate at the largest 6-bit value.
  localparam int DIST_W = 6;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam int CH_W = 8;
  localparam int THR_W = 6;

  // Item kinds.
  localparam logic KIND_REF = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration register indexes.
  localparam int NUM_REGS = 2;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_THRESHOLD = CFG_IDX_W'(1);

  // One input item.
  typedef struct packed {
    logic            kind;
    logic            has_char;
    logic [CH_W-1:0] ch;
    logic            last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              cut_short;
    logic              overflow;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic             cutoff_enable;
    logic [THR_W-1:0] cutoff_threshold;
  } cfg_t;

  // Classified command handed from the front end to the row engine.
  // For a reference command, start means the stored reference is cleared first.
  // For a query command, start means a fresh query is opened.
  typedef struct packed {
    logic            is_ref;
    logic            start;
    logic            has_char;
    logic [CH_W-1:0] ch;
    logic            last;
  } cmd_t;

  // Increment that sticks at the saturation value.
  function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
    logic [DIST_W-1:0] r;
    r = (v == DIST_MAX) ? DIST_MAX : v + DIST_W'(1);
    return r;
  endfunction

  // A length count clipped to the row entry range.
  function automatic logic [DIST_W-1:0] sat_len(input logic [LEN_W-1:0] v);
    logic [DIST_W-1:0] r;
    r = (int'(v) > int'(DIST_MAX)) ? DIST_MAX : DIST_W'(v);
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] min2(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b);
    logic [DIST_W-1:0] r;
    r = (a < b) ? a : b;
    return r;
  endfunction

endpackage

FILE: design/bed_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: design/bed_front.sv
// Front end: accepts items, tracks open words, classifies items and queues commands.
module bed_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bed_pkg::in_item_t in_data,
  output logic             cmd_valid,
  output bed_pkg::cmd_t    cmd_data,
  input  logic             cmd_pop
);

  logic          ref_open_r, ref_open_nxt;
  logic          query_open_r, query_open_nxt;
  bed_pkg::cmd_t q_mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r, count_nxt;
  logic          accept;
  logic          push;
  bed_pkg::cmd_t push_cmd;

  assign in_stall  = (count_r == 2'd2);
  assign accept    = in_valid && !in_stall;
  assign cmd_valid = (count_r != 2'd0);
  assign cmd_data  = q_mem_r[rd_ptr_r];

  // Classify the transfer against the open-word flags.
  always_comb begin
    ref_open_nxt      = ref_open_r;
    query_open_nxt    = query_open_r;
    push              = 1'b0;
    push_cmd.is_ref   = (in_data.kind == bed_pkg::KIND_REF);
    push_cmd.has_char = in_data.has_char;
    push_cmd.ch       = in_data.ch;
    push_cmd.last     = in_data.last;
    push_cmd.start    = 1'b0;
    if (accept) begin
      if (in_data.kind == bed_pkg::KIND_REF) begin
        // A reference item abandons any open query.
        query_open_nxt = 1'b0;
        push_cmd.start = !ref_open_r;
        push           = !ref_open_r || in_data.has_char;
        ref_open_nxt   = !in_data.last;
      end else begin
        // An empty item without last outside a query has no effect.
        push_cmd.start = !query_open_r;
        push           = query_open_r || in_data.has_char || in_data.last;
        if (push) begin
          query_open_nxt = !in_data.last;
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !cmd_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && cmd_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Open-word flags and queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_open_r   <= 1'b1;
      query_open_r <= 1'b0;
      wr_ptr_r     <= 1'b0;
      rd_ptr_r     <= 1'b0;
      count_r      <= 2'd0;
    end else begin
      ref_open_r   <= ref_open_nxt;
      query_open_r <= query_open_nxt;
      count_r      <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (cmd_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: design/bed_back.sv
// Row engine: stores the reference, sweeps one row per query character, emits results.
module bed_back (
  input  logic              clk,
  input  logic              rst_n,
  input  bed_pkg::cfg_t     cfg,
  input  logic              cmd_valid,
  input  bed_pkg::cmd_t     cmd_data,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output bed_pkg::out_item_t out_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0] state_r, state_nxt;

  logic [bed_pkg::LEN_W-1:0]  ref_len_r, ref_len_nxt;
  logic                       ref_over_r, ref_over_nxt;
  logic [bed_pkg::LEN_W-1:0]  qlen_r, qlen_nxt;
  logic                       cut_r, cut_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       fresh_r, fresh_nxt;
  logic [bed_pkg::DIST_W-1:0] row0_r, row0_nxt;
  logic [bed_pkg::DIST_W-1:0] rown_r, rown_nxt;
  logic [bed_pkg::DIST_W-1:0] diag_r, diag_nxt;
  logic [bed_pkg::DIST_W-1:0] left_r, left_nxt;
  logic [bed_pkg::DIST_W-1:0] min_r, min_nxt;
  logic [bed_pkg::LEN_W-1:0]  j_r, j_nxt;
  logic [bed_pkg::CH_W-1:0]   ch_r, ch_nxt;
  logic                       last_r, last_nxt;
  logic                       out_valid_r, out_valid_nxt;
  bed_pkg::out_item_t         out_data_r, out_data_nxt;

  // Effective values of a command after an optional clear or start.
  logic [bed_pkg::LEN_W-1:0]  len_eff;
  logic [bed_pkg::DIST_W-1:0] row0_b;
  logic [bed_pkg::LEN_W-1:0]  qlen_b;
  logic                       cut_b;

  // Store ports.
  logic                       ref_we;
  logic [bed_pkg::ADDR_W-1:0] ref_waddr;
  logic [bed_pkg::CH_W-1:0]   ref_rdata;
  logic [bed_pkg::ADDR_W-1:0] rd_addr;
  logic                       row_we;
  logic [bed_pkg::DIST_W-1:0] row_rdata;
  logic [bed_pkg::LEN_W-1:0]  jm1;

  // Cell of the row being swept.
  logic [bed_pkg::DIST_W-1:0] up;
  logic [bed_pkg::DIST_W-1:0] sub;
  logic [bed_pkg::DIST_W-1:0] d;
  logic                       out_free;

  assign cmd_pop   = cmd_valid && (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign len_eff = cmd_data.start ? '0 : ref_len_r;
  assign row0_b  = cmd_data.start ? '0 : row0_r;
  assign qlen_b  = cmd_data.start ? '0 : qlen_r;
  assign cut_b   = cmd_data.start ? 1'b0 : cut_r;

  assign ref_we    = cmd_pop && cmd_data.is_ref && cmd_data.has_char &&
                     (len_eff < bed_pkg::LEN_W'(bed_pkg::MAX_LEN));
  assign ref_waddr = len_eff[bed_pkg::ADDR_W-1:0];
  assign rd_addr   = (state_r == ST_SWEEP) ? j_r[bed_pkg::ADDR_W-1:0] : '0;
  assign jm1       = j_r - bed_pkg::LEN_W'(1);
  assign row_we    = (state_r == ST_SWEEP);

  // One cell: entry j of the new row from the old entry above, the new entry
  // to the left and the old diagonal.
  always_comb begin
    up  = fresh_r ? bed_pkg::sat_len(j_r) : row_rdata;
    sub = (ref_rdata != ch_r) ? bed_pkg::sat_inc(diag_r) : diag_r;
    d   = bed_pkg::min2(bed_pkg::min2(bed_pkg::sat_inc(up), bed_pkg::sat_inc(left_r)), sub);
  end

  bed_ram #(
    .WIDTH(bed_pkg::CH_W),
    .DEPTH(bed_pkg::MAX_LEN)
  ) u_ref_ram (
    .clk  (clk),
    .we   (ref_we),
    .waddr(ref_waddr),
    .wdata(cmd_data.ch),
    .raddr(rd_addr),
    .rdata(ref_rdata)
  );

  // Row entries 1 to MAX_LEN; entry 0 lives in a register.
  bed_ram #(
    .WIDTH(bed_pkg::DIST_W),
    .DEPTH(bed_pkg::MAX_LEN)
  ) u_row_ram (
    .clk  (clk),
    .we   (row_we),
    .waddr(jm1[bed_pkg::ADDR_W-1:0]),
    .wdata(d),
    .raddr(rd_addr),
    .rdata(row_rdata)
  );

  // Command execution, row sweep and result loading.
  always_comb begin
    state_nxt     = state_r;
    ref_len_nxt   = ref_len_r;
    ref_over_nxt  = ref_over_r;
    qlen_nxt      = qlen_r;
    cut_nxt       = cut_r;
    ovf_nxt       = ovf_r;
    fresh_nxt     = fresh_r;
    row0_nxt      = row0_r;
    rown_nxt      = rown_r;
    diag_nxt      = diag_r;
    left_nxt      = left_r;
    min_nxt       = min_r;
    j_nxt         = j_r;
    ch_nxt        = ch_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_pop && cmd_data.is_ref) begin
          // Reference character appended, or dropped when the store is full.
          ref_len_nxt  = len_eff;
          ref_over_nxt = cmd_data.start ? 1'b0 : ref_over_r;
          if (cmd_data.has_char) begin
            if (len_eff < bed_pkg::LEN_W'(bed_pkg::MAX_LEN)) begin
              ref_len_nxt = len_eff + bed_pkg::LEN_W'(1);
            end else begin
              ref_over_nxt = 1'b1;
            end
          end
        end else if (cmd_pop) begin
          // Query item: open a fresh row if needed, then advance it.
          last_nxt = cmd_data.last;
          row0_nxt = row0_b;
          qlen_nxt = qlen_b;
          cut_nxt  = cut_b;
          if (cmd_data.start) begin
            fresh_nxt = 1'b1;
            rown_nxt  = bed_pkg::sat_len(ref_len_r);
            ovf_nxt   = 1'b0;
          end
          state_nxt = cmd_data.last ? ST_EMIT : ST_IDLE;
          if (cmd_data.has_char) begin
            if (qlen_b >= bed_pkg::LEN_W'(bed_pkg::MAX_LEN)) begin
              ovf_nxt = 1'b1;
            end else begin
              qlen_nxt = qlen_b + bed_pkg::LEN_W'(1);
            end
            if (!cut_b) begin
              row0_nxt = bed_pkg::sat_inc(row0_b);
              if (ref_len_r == '0) begin
                rown_nxt = bed_pkg::sat_inc(row0_b);
              end else begin
                diag_nxt  = row0_b;
                left_nxt  = bed_pkg::sat_inc(row0_b);
                min_nxt   = bed_pkg::sat_inc(row0_b);
                j_nxt     = bed_pkg::LEN_W'(1);
                ch_nxt    = cmd_data.ch;
                state_nxt = ST_SWEEP;
              end
            end
          end
        end
      end
      ST_SWEEP: begin
        diag_nxt = up;
        left_nxt = d;
        min_nxt  = bed_pkg::min2(min_r, d);
        j_nxt    = j_r + bed_pkg::LEN_W'(1);
        if (j_r == ref_len_r) begin
          // Row finished: keep its last entry and test the cutoff.
          fresh_nxt = 1'b0;
          rown_nxt  = d;
          cut_nxt   = cfg.cutoff_enable &&
                      (bed_pkg::min2(min_r, d) > cfg.cutoff_threshold);
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.distance  = cut_r ? bed_pkg::sat_inc(cfg.cutoff_threshold) : rown_r;
          out_data_nxt.cut_short = cut_r;
          out_data_nxt.overflow  = ovf_r || ref_over_r;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ref_len_r   <= '0;
      ref_over_r  <= 1'b0;
      qlen_r      <= '0;
      cut_r       <= 1'b0;
      ovf_r       <= 1'b0;
      fresh_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ref_len_r   <= ref_len_nxt;
      ref_over_r  <= ref_over_nxt;
      qlen_r      <= qlen_nxt;
      cut_r       <= cut_nxt;
      ovf_r       <= ovf_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    row0_r     <= row0_nxt;
    rown_r     <= rown_nxt;
    diag_r     <= diag_nxt;
    left_r     <= left_nxt;
    min_r      <= min_nxt;
    j_r        <= j_nxt;
    ch_r       <= ch_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  // The sweep index stays within the stored reference.
  a_sweep_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (j_r >= bed_pkg::LEN_W'(1) && j_r <= ref_len_r))
    else $error("sweep index outside the reference");

  // The stored reference never grows past the store.
  a_ref_len: assert property (@(posedge clk) disable iff (!rst_n)
    ref_len_r <= bed_pkg::LEN_W'(bed_pkg::MAX_LEN))
    else $error("reference length beyond store depth");

  // A result waiting on a stalled output keeps the engine waiting too.
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_valid_r && out_stall) |=> (state_r == ST_EMIT))
    else $error("result dropped while output stalled");

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");
`endif

endmodule

FILE: design/bounded_edit_distance.sv
// Top level of the bounded edit distance block: configuration registers and the two halves.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    bed_pkg::in_item_t
//   out_     output     out_valid / out_stall  bed_pkg::out_item_t
//   cfg_     input      cfg_we                 cfg_index, cfg_data
//
// A reference item or an item without a character is handled in the idle state.
// A query character then runs the row sweep over the stored reference (up to 32
// entries), which reads and writes one row entry a cycle, unless the reference is
// empty or the query is already cut short.
// A query last then loads the output register, and waits while an earlier result
// is still stalled there.
// A two-entry command queue lets the input accept while the engine sweeps or
// the output is stalled. Reset is synchronous; no clearing pass is needed.
module bounded_edit_distance (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bed_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bed_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [bed_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bed_pkg::CFG_DATA_W-1:0]    cfg_data
);

  bed_pkg::cfg_t cfg_r;
  logic          cmd_valid;
  bed_pkg::cmd_t cmd_data;
  logic          cmd_pop;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cutoff_enable    <= 1'b0;
      cfg_r.cutoff_threshold <= bed_pkg::THR_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bed_pkg::REG_CUTOFF_ENABLE: begin
          cfg_r.cutoff_enable <= cfg_data[0];
        end
        bed_pkg::REG_CUTOFF_THRESHOLD: begin
          cfg_r.cutoff_threshold <= cfg_data[bed_pkg::THR_W-1:0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  bed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cmd_valid(cmd_valid),
    .cmd_data (cmd_data),
    .cmd_pop  (cmd_pop)
  );

  bed_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd_valid(cmd_valid),
    .cmd_data (cmd_data),
    .cmd_pop  (cmd_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the bounded edit distance block: directed table, then random phases.
module testbench;
  import bed_pkg::*;

  // Cycles to let pass after the last result before the block counts as idle.
  localparam int QUIET_CYCLES = 120;
  localparam int PHASE_ITEMS = 76;
  localparam int NUM_PHASES = 7;
  // Register settings of the random phases; a negative threshold means random.
  localparam int PHASE_EN [NUM_PHASES] = '{1, 0, 1, 1, 1, 0, 1};
  localparam int PHASE_THR [NUM_PHASES] = '{32, 63, 63, 1, 3, 0, -1};

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_op_e;

  typedef struct {
    row_op_e                op;
    in_item_t               item;
    bit                     typed;
    out_item_t              want;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  val;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the block's registers and word state.
  bit p_cut_en = 1'b0;
  logic [DIST_W-1:0] p_thr = 6'd2;
  logic [CH_W-1:0] p_ref_chars [0:MAX_LEN-1];
  int p_ref_len = 0;
  bit p_ref_open = 1'b1;
  bit p_ref_over = 1'b0;
  logic [DIST_W-1:0] p_row [0:MAX_LEN];
  int p_q_len = 0;
  bit p_q_open = 1'b0;
  bit p_cut = 1'b0;
  bit p_ovf = 1'b0;

  out_item_t distance_q [$];
  dir_row_t dir_tbl [$];
  logic [CH_W-1:0] gen_ref [$];
  int fail_count = 0;
  int item_count = 0;
  int burst_left = 0;
  logic [7:0] stall_tick = '0;
  stall_mode_e stall_mode = STALL_NONE;

  bounded_edit_distance dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Row entries stick at the largest 6-bit value.
  function automatic logic [DIST_W-1:0] sat_up(input logic [DIST_W-1:0] v);
    return (v == DIST_MAX) ? v : v + DIST_W'(1);
  endfunction

  function automatic logic [DIST_W-1:0] min_of(input logic [DIST_W-1:0] a,
                                               input logic [DIST_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic in_item_t mk_item(input logic k, input logic h,
                                       input logic [CH_W-1:0] c, input logic l);
    in_item_t it;
    it.kind = k;
    it.has_char = h;
    it.ch = c;
    it.last = l;
    return it;
  endfunction

  // Mostly a small alphabet so that words match often, sometimes any byte.
  function automatic logic [CH_W-1:0] pick_char();
    return ($urandom_range(0, 9) < 7) ? 8'h61 + 8'($urandom_range(0, 3))
                                      : 8'($urandom_range(0, 255));
  endfunction

  // Advance the shadow state by one item; returns the distance result it causes.
  task automatic levenshtein_step(input in_item_t it, output bit emits,
                                  output out_item_t res, output bit took);
    logic [DIST_W-1:0] diag, up, sub, d, row_min;
    int j;
    emits = 1'b0;
    res = '0;
    took = 1'b1;
    if (it.kind == KIND_REF) begin
      // A reference item abandons any open query and appends to the reference.
      p_q_open = 1'b0;
      if (!p_ref_open) begin
        p_ref_len = 0;
        p_ref_over = 1'b0;
        p_ref_open = 1'b1;
      end
      if (it.has_char) begin
        if (p_ref_len < MAX_LEN) begin
          p_ref_chars[p_ref_len] = it.ch;
          p_ref_len++;
        end else begin
          p_ref_over = 1'b1;
        end
      end
      if (it.last) p_ref_open = 1'b0;
      return;
    end
    if (!p_q_open) begin
      if (!it.has_char && !it.last) begin
        took = 1'b0;
        return;
      end
      for (j = 0; j <= p_ref_len; j++) p_row[j] = DIST_W'(j);
      p_q_len = 0;
      p_cut = 1'b0;
      p_ovf = 1'b0;
      p_q_open = 1'b1;
    end
    if (it.has_char) begin
      if (p_q_len >= MAX_LEN) p_ovf = 1'b1;
      else p_q_len++;
      // One row of unit-cost insert, delete and substitute.
      if (!p_cut) begin
        diag = p_row[0];
        p_row[0] = sat_up(p_row[0]);
        row_min = p_row[0];
        for (j = 1; j <= p_ref_len; j++) begin
          up = p_row[j];
          sub = (p_ref_chars[j-1] != it.ch) ? sat_up(diag) : diag;
          d = min_of(min_of(sat_up(up), sat_up(p_row[j-1])), sub);
          diag = up;
          p_row[j] = d;
          row_min = min_of(row_min, d);
        end
        if (p_cut_en && p_ref_len > 0 && row_min > p_thr) p_cut = 1'b1;
      end
    end
    if (!it.last) return;
    res.distance = p_cut ? sat_up(p_thr) : p_row[p_ref_len];
    res.cut_short = p_cut;
    res.overflow = p_ovf || p_ref_over;
    emits = 1'b1;
    p_q_open = 1'b0;
  endtask

  // Send one item in bursts with random gaps, then predict its result.
  task automatic transfer_item(input in_item_t it, input bit typed, input out_item_t want);
    bit emits, took;
    out_item_t res;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8))
          @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    levenshtein_step(it, emits, res, took);
    if (emits) distance_q.push_back(typed ? want : res);
    if (took) item_count++;
  endtask

  task automatic send_item(input in_item_t it);
    transfer_item(it, 1'b0, '0);
  endtask

  // Stop sending, wait for every pending result, then let the engine go quiet.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (distance_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CUTOFF_ENABLE) p_cut_en = val[0];
    else if (idx == REG_CUTOFF_THRESHOLD) p_thr = val[THR_W-1:0];
    @(posedge clk);
  endtask

  function automatic void add_item(input logic k, input logic h,
                                   input logic [CH_W-1:0] c, input logic l);
    dir_row_t r;
    r.op = ROW_ITEM;
    r.item = mk_item(k, h, c, l);
    r.typed = 1'b0;
    r.want = '0;
    r.idx = '0;
    r.val = '0;
    dir_tbl.push_back(r);
  endfunction

  function automatic void add_typed(input logic k, input logic h, input logic [CH_W-1:0] c,
                                    input logic l, input logic [DIST_W-1:0] want_dist,
                                    input logic cut, input logic ovf);
    dir_row_t r;
    r.op = ROW_ITEM;
    r.item = mk_item(k, h, c, l);
    r.typed = 1'b1;
    r.want.distance = want_dist;
    r.want.cut_short = cut;
    r.want.overflow = ovf;
    r.idx = '0;
    r.val = '0;
    dir_tbl.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r.op = ROW_CFG;
    r.item = '0;
    r.typed = 1'b0;
    r.want = '0;
    r.idx = idx;
    r.val = val;
    dir_tbl.push_back(r);
  endfunction

  // One reference word, closed either on its last character or by an empty item.
  task automatic send_reference();
    int len, i;
    bit close_empty;
    case ($urandom_range(0, 9))
      0, 1: len = $urandom_range(7, MAX_LEN);
      2:    len = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
      default: len = $urandom_range(0, 6);
    endcase
    close_empty = (len == 0) || ($urandom_range(0, 4) == 0);
    gen_ref.delete();
    for (i = 0; i < len; i++) gen_ref.push_back(pick_char());
    for (i = 0; i < len; i++)
      send_item(mk_item(KIND_REF, 1'b1, gen_ref[i], !close_empty && (i == len - 1)));
    if (close_empty) send_item(mk_item(KIND_REF, 1'b0, 8'($urandom_range(0, 255)), 1'b1));
  endtask

  // One query word: a near copy of the reference, a random word or a long one.
  task automatic send_query();
    logic [CH_W-1:0] q [$];
    int i, len, r, stop_at;
    bit close_empty;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      foreach (gen_ref[k]) begin
        case ($urandom_range(0, 99) / 7)
          0: q.push_back(pick_char());
          1: ;
          2: begin
            q.push_back(pick_char());
            q.push_back(gen_ref[k]);
          end
          default: q.push_back(gen_ref[k]);
        endcase
      end
    end else begin
      len = (r < 95) ? $urandom_range(0, 10) : $urandom_range(MAX_LEN + 1, 70);
      for (i = 0; i < len; i++) q.push_back(pick_char());
    end
    close_empty = (q.size() == 0) || ($urandom_range(0, 4) == 0);
    // Now and then the query is left open; later items continue it or a reference abandons it.
    stop_at = ($urandom_range(0, 19) == 0) ? q.size() / 2 : q.size();
    for (i = 0; i < stop_at; i++)
      send_item(mk_item(KIND_QUERY, 1'b1, q[i], !close_empty && (i == q.size() - 1)));
    if (stop_at == q.size() && close_empty)
      send_item(mk_item(KIND_QUERY, 1'b0, 8'($urandom_range(0, 255)), 1'b1));
  endtask

  task automatic run_random(input int target);
    int nq, i;
    item_count = 0;
    while (item_count < target) begin
      if ($urandom_range(0, 99) < 12) begin
        send_item(mk_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      end else begin
        if (gen_ref.size() == 0 || $urandom_range(0, 99) < 45) send_reference();
        nq = $urandom_range(1, 3);
        for (i = 0; i < nq; i++) send_query();
      end
    end
  endtask

  // The receiver picks a new random stall pattern whenever the low six bits of stall_tick are zero.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    if (stall_tick[5:0] == 6'd0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 99) < 70);
      STALL_PERIODIC: out_stall <= (stall_tick[1:0] == 2'b11);
    endcase
  end

  // Compare every result transfer with the oldest predicted distance.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (distance_q.size() == 0) begin
        $error("result with nothing pending: distance %0d", out_data.distance);
        fail_count++;
      end else begin
        want = distance_q.pop_front();
        if (out_data.distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, out_data.distance);
          fail_count++;
        end
        if (out_data.cut_short !== want.cut_short) begin
          $error("cut_short: expected %0d, got %0d", want.cut_short, out_data.cut_short);
          fail_count++;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, out_data.overflow);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int ph, thr;
    // Under the reset settings: empty words, exact match, extreme bytes.
    add_typed(KIND_QUERY, 1'b0, 8'h00, 1'b1, 6'd0, 1'b0, 1'b0);
    add_item(KIND_REF, 1'b1, 8'h61, 1'b0);
    add_item(KIND_REF, 1'b1, 8'h62, 1'b1);
    add_typed(KIND_QUERY, 1'b0, 8'hFF, 1'b1, 6'd2, 1'b0, 1'b0);
    add_item(KIND_QUERY, 1'b1, 8'h61, 1'b0);
    add_typed(KIND_QUERY, 1'b1, 8'h62, 1'b1, 6'd0, 1'b0, 1'b0);
    add_item(KIND_QUERY, 1'b1, 8'hFF, 1'b0);
    add_typed(KIND_QUERY, 1'b1, 8'h00, 1'b1, 6'd2, 1'b0, 1'b0);
    // An empty reference item without last still opens a new reference word.
    add_item(KIND_REF, 1'b0, 8'hFF, 1'b0);
    // Cutoff at threshold zero: the first mismatching row cuts the query short.
    add_cfg(REG_CUTOFF_ENABLE, 6'd1);
    add_cfg(REG_CUTOFF_THRESHOLD, 6'd0);
    add_item(KIND_REF, 1'b1, 8'h78, 1'b0);
    add_item(KIND_REF, 1'b1, 8'h79, 1'b1);
    add_item(KIND_QUERY, 1'b1, 8'h61, 1'b0);
    add_item(KIND_QUERY, 1'b1, 8'h62, 1'b0);
    add_typed(KIND_QUERY, 1'b0, 8'h00, 1'b1, 6'd1, 1'b1, 1'b0);
    // A reference item in the middle of a query abandons that query.
    add_item(KIND_QUERY, 1'b1, 8'h78, 1'b0);
    add_item(KIND_REF, 1'b1, 8'h71, 1'b1);
    add_typed(KIND_QUERY, 1'b1, 8'h71, 1'b1, 6'd0, 1'b0, 1'b0);
    // Empty reference: the query length comes back and no cutoff applies.
    add_item(KIND_REF, 1'b0, 8'h00, 1'b1);
    add_item(KIND_QUERY, 1'b1, 8'h61, 1'b0);
    add_typed(KIND_QUERY, 1'b1, 8'h62, 1'b1, 6'd2, 1'b0, 1'b0);
    add_item(KIND_QUERY, 1'b0, 8'hAA, 1'b0);
    add_typed(KIND_QUERY, 1'b1, 8'h7A, 1'b1, 6'd1, 1'b0, 1'b0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].op == ROW_CFG) begin
        quiesce();
        write_reg(dir_tbl[i].idx, dir_tbl[i].val);
      end else begin
        transfer_item(dir_tbl[i].item, dir_tbl[i].typed, dir_tbl[i].want);
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      thr = (PHASE_THR[ph] < 0) ? $urandom_range(0, 63) : PHASE_THR[ph];
      quiesce();
      write_reg(REG_CUTOFF_ENABLE, CFG_DATA_W'(PHASE_EN[ph]));
      write_reg(REG_CUTOFF_THRESHOLD, CFG_DATA_W'(thr));
      run_random(PHASE_ITEMS);
    end

    quiesce();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
